@@ sv/dlr_pkg.sv @@
package dlr_pkg;

  localparam int DLR_FRAC_BITS    = 16;
  localparam int DLR_SCREEN_WIDTH = 1024;

  localparam int COORD_W = 10;
  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 32;
  localparam int IN_W    = 4 * COORD_W + COLOR_W;
  localparam int OUT_W   = 2 * COORD_W + ADDR_W + COLOR_W;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] mag;
    logic [COORD_W-1:0] divisor;
  } dlr_div_req_t;

endpackage

@@ sv/dda_line_rasterizer.sv @@
// DDA line rasterizer. A start transaction (tuser low) latches two endpoints and a color,
// then computes the per-axis increments with a shared restoring divider that produces one
// quotient bit per cycle; the two axes run one after the other, so a nonzero-length start
// holds s_tready low until both divisions finish and gives no output. Each step transaction
// (tuser high) emits one pixel with its rounded position, frame-buffer address and color;
// tlast marks the final pixel, and the end point itself is not drawn. A zero-length line
// and a step with no line in progress give no output. A two-entry output buffer lets one
// more step transaction be accepted while the output side stalls.
module dda_line_rasterizer import dlr_pkg::*; #(
  parameter int FRAC_BITS = DLR_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y, line_color
  input  logic             s_tuser,  // action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color
  output logic             m_tlast
);

  localparam int POS_W  = COORD_W + 1 + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVX = 2'd1;
  localparam logic [1:0] ST_DIVY = 2'd2;

  logic [1:0]         state;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [STEP_W-1:0]  step_x;
  logic [STEP_W-1:0]  step_y;
  logic [COORD_W-1:0] steps_left;
  logic [COLOR_W-1:0] held_color;
  logic               line_active;
  logic               neg_x;
  logic               neg_y;
  logic [COORD_W-1:0] ady_q;

  logic               skid_valid;
  logic [OUT_W-1:0]   skid_data;
  logic               skid_last;

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic [COLOR_W-1:0] color_in;
  logic [COORD_W-1:0] adx, ady, len;
  logic               in_fire, start_fire, step_fire, pix_fire;

  dlr_div_req_t       div_req;
  logic               div_done;
  logic [FRAC_BITS:0] div_quot;
  logic [STEP_W-1:0]  step_pos, step_new;

  logic [COORD_W-1:0] px, py;
  logic [ADDR_W-1:0]  addr;
  logic [OUT_W-1:0]   pix_data;
  logic               pix_last;

  always_comb begin
    x0       = s_tdata[COORD_W-1:0];
    y0       = s_tdata[2*COORD_W-1:COORD_W];
    x1       = s_tdata[3*COORD_W-1:2*COORD_W];
    y1       = s_tdata[4*COORD_W-1:3*COORD_W];
    color_in = s_tdata[IN_W-1:4*COORD_W];
    adx      = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady      = (y1 >= y0) ? y1 - y0 : y0 - y1;
    len      = (adx >= ady) ? adx : ady;

    s_tready   = (state == ST_IDLE) && !skid_valid;
    in_fire    = s_tvalid && s_tready;
    start_fire = in_fire && (s_tuser == ACT_START);
    step_fire  = in_fire && (s_tuser == ACT_STEP);
    pix_fire   = step_fire && line_active && (steps_left != '0);

    div_req.start   = (start_fire && (len != '0)) || ((state == ST_DIVX) && div_done);
    div_req.mag     = (state == ST_DIVX) ? ady_q : adx;
    div_req.divisor = (state == ST_DIVX) ? steps_left : len;

    step_pos = STEP_W'({1'b0, div_quot});
    step_new = ((state == ST_DIVX) ? neg_x : neg_y) ? STEP_W'(0) - step_pos : step_pos;

    pix_data = {held_color, addr, py, px};
    pix_last = (steps_left == COORD_W'(1));
  end

  dlr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  dlr_pixel #(.FRAC_BITS(FRAC_BITS)) u_pixel (
    .pos_x (pos_x),
    .pos_y (pos_y),
    .px    (px),
    .py    (py),
    .addr  (addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_active <= 1'b0;
      steps_left  <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      step_x      <= '0;
      step_y      <= '0;
      held_color  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start_fire) begin
            held_color  <= color_in;
            pos_x       <= POS_W'({x0, {FRAC_BITS{1'b0}}});
            pos_y       <= POS_W'({y0, {FRAC_BITS{1'b0}}});
            steps_left  <= len;
            line_active <= 1'b0;
            if (len == '0) begin
              step_x <= '0;
              step_y <= '0;
            end else begin
              state <= ST_DIVX;
            end
          end else if (step_fire) begin
            if (pix_fire) begin
              pos_x      <= pos_x + POS_W'(signed'(step_x));
              pos_y      <= pos_y + POS_W'(signed'(step_y));
              steps_left <= steps_left - 1'b1;
              if (steps_left == COORD_W'(1)) begin
                line_active <= 1'b0;
              end
            end else begin
              line_active <= 1'b0;
            end
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            step_x <= step_new;
            state  <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            step_y      <= step_new;
            line_active <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      neg_x <= x1 < x0;
      neg_y <= y1 < y0;
      ady_q <= ady;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (pix_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (pix_fire) begin
        skid_data <= pix_data;
        skid_last <= pix_last;
      end
    end else if (skid_valid) begin
      m_tdata <= skid_data;
      m_tlast <= skid_last;
    end else if (pix_fire) begin
      m_tdata <= pix_data;
      m_tlast <= pix_last;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input accepted while the divider is running");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held with an empty output register");

  a_active_has_steps: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (steps_left != '0))
    else $error("line active with no pixels left");

  a_divy_activates: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIVY) && div_done) |=> (line_active && (state == ST_IDLE)))
    else $error("line not armed after the second division");

endmodule

@@ sv/dlr_div.sv @@
module dlr_div import dlr_pkg::*; #(
  parameter int FRAC_BITS = DLR_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  dlr_div_req_t       req,
  output logic               done,
  output logic [FRAC_BITS:0] quot
);

  localparam int DW    = COORD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DW-1:0]      acc;
  logic [COORD_W-1:0] rem;
  logic [COORD_W-1:0] divisor;

  logic [COORD_W:0]   rem_sh;
  logic               ge;
  logic [COORD_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, acc[DW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_next = ge ? COORD_W'(rem_sh - {1'b0, divisor}) : rem_sh[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= {req.mag, {FRAC_BITS{1'b0}}};
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      acc <= {acc[DW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quot = acc[FRAC_BITS:0];

endmodule

@@ sv/dlr_pixel.sv @@
module dlr_pixel import dlr_pkg::*; #(
  parameter int FRAC_BITS = DLR_FRAC_BITS
) (
  input  logic [COORD_W+FRAC_BITS:0] pos_x,
  input  logic [COORD_W+FRAC_BITS:0] pos_y,
  output logic [COORD_W-1:0]         px,
  output logic [COORD_W-1:0]         py,
  output logic [ADDR_W-1:0]          addr
);

  localparam int POS_W = COORD_W + 1 + FRAC_BITS;

  logic [POS_W:0] sum_x;
  logic [POS_W:0] sum_y;

  always_comb begin
    sum_x = {1'b0, pos_x} + ((POS_W + 1)'(1) << (FRAC_BITS - 1));
    sum_y = {1'b0, pos_y} + ((POS_W + 1)'(1) << (FRAC_BITS - 1));
    px    = sum_x[FRAC_BITS+COORD_W-1:FRAC_BITS];
    py    = sum_y[FRAC_BITS+COORD_W-1:FRAC_BITS];
    addr  = ADDR_W'(ADDR_W'(py) * ADDR_W'(DLR_SCREEN_WIDTH)) + ADDR_W'(px);
  end

endmodule
